### rtl/multi_drive_step_tone_generator_core_assert.svh
// Assertion macros shared by the tone generator RTL.
`ifndef MULTI_DRIVE_STEP_TONE_GENERATOR_CORE_ASSERT_SVH
`define MULTI_DRIVE_STEP_TONE_GENERATOR_CORE_ASSERT_SVH

// Checked at every clock edge once reset is released.
`define MDSTG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define MDSTG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### rtl/mdstg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mdstg_pkg;

    // Drive bank geometry
    localparam int DRIVES  = 9;
    localparam int DRV_W   = (DRIVES > 1) ? $clog2(DRIVES) : 1;
    localparam int DNUM_W  = $clog2(DRIVES + 1);
    localparam int DFLD_W  = 4;
    localparam int DCMP_W  = (DNUM_W > DFLD_W) ? DNUM_W : DFLD_W;

    // Field widths
    localparam int OP_W    = 3;
    localparam int NOTE_W  = 7;
    localparam int HP_W    = 9;
    localparam int POS_W   = 8;
    localparam int OUT_W   = 9;
    localparam int PAD_W   = (DRIVES > OUT_W) ? DRIVES : OUT_W;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [POS_W-1:0] MAX_POS_RESET = 8'd158;

    // Register word indexes
    typedef enum logic [0:0] {
        REG_TURN_POS = 1'b0
    } reg_idx_t;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_NOTE_ON  = 3'd1,
        OP_NOTE_OFF = 3'd2,
        OP_RESET    = 3'd3,
        OP_HALT     = 3'd4
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DFLD_W-1:0] drive;
        logic [NOTE_W-1:0] note;
    } req_t;

    typedef struct packed {
        logic [OUT_W-1:0] step_levels;
        logic [OUT_W-1:0] direction_levels;
        logic [OUT_W-1:0] stepped;
    } rsp_t;

    // One drive's working state
    typedef struct packed {
        logic [HP_W-1:0]  half_period;
        logic [HP_W-1:0]  tick_count;
        logic [POS_W-1:0] position;
        logic             reverse;
        logic             level;
    } drv_state_t;

    // Control to the shared drive update unit
    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic            hit;
        logic            clear_all;
        logic [HP_W-1:0] note_period;
    } alu_ctl_t;

    // Pitch table: half-period in 40 us ticks (period in us / 80), C1..B4
    function automatic logic [HP_W-1:0] pitch_ticks(input logic [NOTE_W-1:0] note);
        logic [HP_W-1:0] t;
        begin
            case (note)
                7'd24: t = 9'd382;  7'd25: t = 9'd360;  7'd26: t = 9'd340;
                7'd27: t = 9'd321;  7'd28: t = 9'd303;  7'd29: t = 9'd286;
                7'd30: t = 9'd270;  7'd31: t = 9'd255;  7'd32: t = 9'd240;
                7'd33: t = 9'd227;  7'd34: t = 9'd214;  7'd35: t = 9'd202;
                7'd36: t = 9'd191;  7'd37: t = 9'd180;  7'd38: t = 9'd170;
                7'd39: t = 9'd160;  7'd40: t = 9'd151;  7'd41: t = 9'd143;
                7'd42: t = 9'd135;  7'd43: t = 9'd127;  7'd44: t = 9'd120;
                7'd45: t = 9'd113;  7'd46: t = 9'd107;  7'd47: t = 9'd101;
                7'd48: t = 9'd95;   7'd49: t = 9'd90;   7'd50: t = 9'd85;
                7'd51: t = 9'd80;   7'd52: t = 9'd75;   7'd53: t = 9'd71;
                7'd54: t = 9'd67;   7'd55: t = 9'd63;   7'd56: t = 9'd60;
                7'd57: t = 9'd56;   7'd58: t = 9'd53;   7'd59: t = 9'd50;
                7'd60: t = 9'd47;   7'd61: t = 9'd45;   7'd62: t = 9'd42;
                7'd63: t = 9'd40;   7'd64: t = 9'd37;   7'd65: t = 9'd35;
                7'd66: t = 9'd33;   7'd67: t = 9'd31;   7'd68: t = 9'd30;
                7'd69: t = 9'd28;   7'd70: t = 9'd26;   7'd71: t = 9'd25;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/mdstg_drive_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared update unit: next state of one drive for the current request
module mdstg_drive_alu import mdstg_pkg::*; (
    input  wire alu_ctl_t         ctl,
    input  wire logic [POS_W-1:0] turn_pos,
    input  wire drv_state_t       cur,
    output drv_state_t            nxt,
    output logic                  stepped
);

    logic [HP_W-1:0] cnt_inc;
    logic            fire;
    logic            dir_new;

    // Tick counter and fire compare
    assign cnt_inc = cur.tick_count + HP_W'(1);
    assign fire    = (cur.half_period != '0) && (cnt_inc >= cur.half_period);

    // Direction bounces at the turn position and at zero
    always_comb begin
        if (cur.position >= turn_pos) begin
            dir_new = 1'b1;
        end else if (cur.position == '0) begin
            dir_new = 1'b0;
        end else begin
            dir_new = cur.reverse;
        end
    end

    always_comb begin
        nxt     = cur;
        stepped = 1'b0;
        case (op_t'(ctl.operation))
            OP_TICK: begin
                if (cur.half_period != '0) begin
                    if (fire) begin
                        nxt.tick_count = '0;
                        nxt.reverse    = dir_new;
                        nxt.level      = ~cur.level;
                        stepped        = 1'b1;
                        if (!dir_new) begin
                            nxt.position = cur.position + POS_W'(1);
                        end else if (cur.position != '0) begin
                            nxt.position = cur.position - POS_W'(1);
                        end
                    end else begin
                        nxt.tick_count = cnt_inc;
                    end
                end
            end
            OP_NOTE_ON: begin
                if (ctl.hit) begin
                    nxt.half_period = ctl.note_period;
                end
            end
            OP_NOTE_OFF: begin
                if (ctl.hit) begin
                    nxt.half_period = '0;
                end
            end
            OP_RESET: begin
                // tick count is kept across a drive reset
                if (ctl.hit || ctl.clear_all) begin
                    nxt.half_period = '0;
                    nxt.position    = '0;
                    nxt.reverse     = 1'b0;
                    nxt.level       = 1'b0;
                end
            end
            OP_HALT: begin
                nxt.half_period = '0;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/multi_drive_step_tone_generator_core.sv
// Sequence: a request is accepted in the idle state, the single drive update unit
//   then visits one drive per cycle over all 9 drives, and the result is loaded
//   in the done state once the result register is free.
// A new request is taken while the previous result still waits on m_ready.
// Reset: synchronous, active low; clears every drive at once, turn position to 158.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_drive_step_tone_generator_core_assert.svh"

module multi_drive_step_tone_generator_core import mdstg_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // requests
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire req_t                  s_data,
    // results
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output rsp_t                       m_data
);

    st_t              state_reg, state_next;
    logic [DRV_W-1:0] idx_reg;
    req_t             req_reg;
    logic [HP_W-1:0]  note_period_reg;
    logic [POS_W-1:0] max_pos_reg;
    logic             m_valid_reg;
    rsp_t             m_data_reg;
    logic [DRIVES-1:0] stepped_reg;

    // per-drive state
    logic [HP_W-1:0]   hp_reg  [DRIVES];
    logic [HP_W-1:0]   cnt_reg [DRIVES];
    logic [POS_W-1:0]  pos_reg [DRIVES];
    logic [DRIVES-1:0] dir_reg;
    logic [DRIVES-1:0] lvl_reg;

    logic       accept;
    logic       sweep_end;
    logic       out_free;
    logic       cfg_wr;
    alu_ctl_t   ctl;
    drv_state_t cur;
    drv_state_t nxt;
    logic       alu_stepped;
    logic [PAD_W-1:0] lvl_pad;
    logic [PAD_W-1:0] dir_pad;
    logic [PAD_W-1:0] stp_pad;

    assign accept    = s_valid && s_ready;
    assign sweep_end = (idx_reg == DRV_W'(DRIVES - 1));
    assign out_free  = !m_valid_reg || m_ready;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (reg_idx_t'(paddr[2]) == REG_TURN_POS) begin
            prdata = APB_DATA_W'(max_pos_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pos_reg <= MAX_POS_RESET;
        end else if (cfg_wr && reg_idx_t'(paddr[2]) == REG_TURN_POS) begin
            max_pos_reg <= pwdata[POS_W-1:0];
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (sweep_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            default: s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (accept || sweep_end) begin
                idx_reg <= '0;
            end else if (state_reg == ST_RUN) begin
                idx_reg <= idx_reg + DRV_W'(1);
            end
        end
    end

    // Request capture; pitch lookup done once here
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg         <= s_data;
            note_period_reg <= pitch_ticks(s_data.note);
        end
    end

    // Drive update unit, fed with the drive under the sweep index
    assign ctl.operation   = req_reg.operation;
    assign ctl.hit         = (DCMP_W'(req_reg.drive) == DCMP_W'(idx_reg) + DCMP_W'(1));
    assign ctl.clear_all   = (req_reg.drive == '0);
    assign ctl.note_period = note_period_reg;

    assign cur.half_period = hp_reg[idx_reg];
    assign cur.tick_count  = cnt_reg[idx_reg];
    assign cur.position    = pos_reg[idx_reg];
    assign cur.reverse     = dir_reg[idx_reg];
    assign cur.level       = lvl_reg[idx_reg];

    mdstg_drive_alu u_alu (
        .ctl      (ctl),
        .turn_pos (max_pos_reg),
        .cur      (cur),
        .nxt      (nxt),
        .stepped  (alu_stepped)
    );

    // Drive state write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DRIVES; i++) begin
                hp_reg[i]  <= '0;
                cnt_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            dir_reg     <= '0;
            lvl_reg     <= '0;
            stepped_reg <= '0;
        end else if (accept) begin
            stepped_reg <= '0;
        end else if (state_reg == ST_RUN) begin
            hp_reg[idx_reg]      <= nxt.half_period;
            cnt_reg[idx_reg]     <= nxt.tick_count;
            pos_reg[idx_reg]     <= nxt.position;
            dir_reg[idx_reg]     <= nxt.reverse;
            lvl_reg[idx_reg]     <= nxt.level;
            stepped_reg[idx_reg] <= alu_stepped;
        end
    end

    // Result register
    assign lvl_pad = PAD_W'(lvl_reg);
    assign dir_pad = PAD_W'(dir_reg);
    assign stp_pad = PAD_W'(stepped_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg.step_levels      <= lvl_pad[OUT_W-1:0];
            m_data_reg.direction_levels <= dir_pad[OUT_W-1:0];
            m_data_reg.stepped          <= stp_pad[OUT_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `MDSTG_ASSERT(a_accept_starts_sweep, accept |=> (state_reg == ST_RUN && idx_reg == '0), "accepted request did not start the drive sweep")
    `MDSTG_ASSERT(a_sweep_ends, (state_reg == ST_RUN && sweep_end) |=> (state_reg == ST_DONE), "sweep did not end after the last drive")
    `MDSTG_ASSERT(a_silent_no_step, (state_reg == ST_RUN && cur.half_period == '0) |=> (stepped_reg == $past(stepped_reg)), "silent drive stepped")
    `MDSTG_ASSERT(a_result_from_done, $rose(m_valid_reg) |-> ($past(state_reg) == ST_DONE), "result raised outside the done state")

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import mdstg_pkg::*;

    localparam int NDRV         = DRIVES;
    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 120;
    localparam int DRAIN_CYCLES = 24;
    localparam int ROM_DIVISOR  = 80;
    localparam int FIRST_NOTE   = 24;
    localparam int NOTE_SPAN    = 48;

    // Operation codes the block has no meaning for
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic [APB_ADDR_W-1:0] ADDR_TURN_POS =
        APB_ADDR_W'(4 * int'(REG_TURN_POS));

    // DUT signals
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    req_t                  s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    rsp_t                  m_data;

    // Drive bank shadow state
    logic [HP_W-1:0]  drv_period [NDRV];
    logic [HP_W-1:0]  drv_count  [NDRV];
    logic [POS_W-1:0] drv_pos    [NDRV];
    logic             drv_rev    [NDRV];
    logic             drv_lvl    [NDRV];
    logic [HP_W-1:0]  pitch_table [128];
    logic [POS_W-1:0] max_pos;

    // Period in microseconds for notes C1..B4
    int unsigned note_period_us [NOTE_SPAN] = '{
        30578, 28861, 27242, 25713, 24270, 22909, 21622, 20409, 19263, 18182, 17161, 16198,
        15289, 14436, 13621, 12856, 12135, 11454, 10811, 10205,  9632,  9091,  8581,  8099,
         7645,  7218,  6811,  6428,  6068,  5727,  5406,  5103,  4816,  4546,  4291,  4050,
         3823,  3609,  3406,  3214,  3034,  2864,  2703,  2552,  2408,  2273,  2146,  2025
    };

    req_t request_q [$];
    rsp_t expected_rsp [$];
    int   queued_total   = 0;
    int   mismatch_count = 0;
    int   results_seen   = 0;
    int   idle_cycles    = 0;
    bit   calm           = 1'b0;

    multi_drive_step_tone_generator_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    function automatic void silence_drive(input int d);
        drv_period[d] = '0;
        drv_pos[d]    = '0;
        drv_lvl[d]    = 1'b0;
        drv_rev[d]    = 1'b0;
    endfunction

    // Apply one request to the shadow bank and return the levels it leaves
    function automatic rsp_t tone_step(input req_t r);
        rsp_t res;
        logic hit;
        int   d;
        res = '0;
        hit = (r.drive >= 1) && (r.drive <= NDRV);
        d   = hit ? int'(r.drive) - 1 : 0;
        case (r.operation)
            OP_TICK: begin
                for (int i = 0; i < NDRV; i++) begin
                    if (drv_period[i] != '0) begin
                        drv_count[i] = drv_count[i] + 1'b1;
                        if (drv_count[i] >= drv_period[i]) begin
                            drv_count[i] = '0;
                            // turn around at the ends before moving
                            if (drv_pos[i] >= max_pos) begin
                                drv_rev[i] = 1'b1;
                            end else if (drv_pos[i] == '0) begin
                                drv_rev[i] = 1'b0;
                            end
                            if (drv_rev[i]) begin
                                if (drv_pos[i] != '0) begin
                                    drv_pos[i] = drv_pos[i] - 1'b1;
                                end
                            end else begin
                                drv_pos[i] = drv_pos[i] + 1'b1;
                            end
                            drv_lvl[i] = ~drv_lvl[i];
                            if (i < OUT_W) begin
                                res.stepped[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_NOTE_ON: begin
                if (hit) begin
                    drv_period[d] = pitch_table[r.note];
                end
            end
            OP_NOTE_OFF: begin
                if (hit) begin
                    drv_period[d] = '0;
                end
            end
            OP_RESET: begin
                if (r.drive == '0) begin
                    for (int i = 0; i < NDRV; i++) begin
                        silence_drive(i);
                    end
                end else if (hit) begin
                    silence_drive(d);
                end
            end
            OP_HALT: begin
                for (int i = 0; i < NDRV; i++) begin
                    drv_period[i] = '0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < NDRV && i < OUT_W; i++) begin
            res.step_levels[i]      = drv_lvl[i];
            res.direction_levels[i] = drv_rev[i];
        end
        return res;
    endfunction

    task automatic push_req(input logic [OP_W-1:0] op, input int drv, input int note);
        req_t r;
        r.operation = op;
        r.drive     = DFLD_W'(drv);
        r.note      = NOTE_W'(note);
        request_q.push_back(r);
        if (op <= OP_HALT) begin
            queued_total++;
        end
    endtask

    // Mostly playable notes so that steps come often
    function automatic int pick_note();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7) begin
            return $urandom_range(60, 71);
        end else if (p < 9) begin
            return $urandom_range(FIRST_NOTE, 59);
        end
        return $urandom_range(0, 127);
    endfunction

    task automatic run_phase(input int quota);
        int start, pick, d, k;
        start = queued_total;
        while (queued_total - start < quota) begin
            pick = $urandom_range(0, 99);
            d    = $urandom_range(1, NDRV);
            if (pick < 8) begin
                // noise: any code, any drive number, any note
                push_req(OP_W'($urandom_range(0, 7)), $urandom_range(0, 15),
                         $urandom_range(0, 127));
            end else if (pick < 22) begin
                push_req(OP_NOTE_ON, d, pick_note());
            end else if (pick < 25) begin
                push_req(OP_NOTE_OFF, d, $urandom_range(0, 127));
            end else if (pick < 27) begin
                push_req(OP_RESET, ($urandom_range(0, 9) == 0) ? 0 : d, $urandom_range(0, 127));
            end else if (pick < 28) begin
                push_req(OP_HALT, $urandom_range(0, 15), $urandom_range(0, 127));
            end else if (pick < 31) begin
                // long period, then a short one while the count is already past it
                push_req(OP_NOTE_ON, d, $urandom_range(FIRST_NOTE, 50));
                k = $urandom_range(31, 45);
                repeat (k) push_req(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 127));
                push_req(OP_NOTE_ON, d, $urandom_range(68, 71));
                push_req(OP_TICK, d, 0);
            end else begin
                k = $urandom_range(1, 30);
                repeat (k) push_req(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 127));
            end
        end
    endtask

    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (!(request_q.size() == 0 && !s_valid && expected_rsp.size() == 0));
    endtask

    // Write the turn position, read it back, update the shadow copy
    task automatic set_turn_pos(input logic [POS_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TURN_POS;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        max_pos = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[POS_W-1:0] !== value) begin
            note_failure($sformatf("turn position readback: expected %h, got %h", value, rd));
        end
    endtask

    // Request driver
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_rsp.push_back(tone_step(s_data));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    s_data  <= request_q.pop_front();
                    s_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        gap_left = $urandom_range(1, 18);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                               input logic [OUT_W-1:0] got);
        if (got !== want) begin
            note_failure($sformatf("%s: expected %h, got %h", name, want, got));
        end
    endtask

    // Result monitor
    always @(posedge aclk) begin : monitor
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (expected_rsp.size() == 0) begin
                note_failure($sformatf("result with no request pending: %h", m_data));
            end else begin
                want = expected_rsp.pop_front();
                check_field("step_levels", want.step_levels, m_data.step_levels);
                check_field("direction_levels", want.direction_levels,
                            m_data.direction_levels);
                check_field("stepped", want.stepped, m_data.stepped);
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_drive_step_tone_generator_core test failed");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < 128; n++) begin
            pitch_table[n] = '0;
            if (n >= FIRST_NOTE && n < FIRST_NOTE + NOTE_SPAN) begin
                pitch_table[n] = HP_W'(note_period_us[n - FIRST_NOTE] / ROM_DIVISOR);
            end
        end
        for (int i = 0; i < NDRV; i++) begin
            silence_drive(i);
            drv_count[i] = '0;
        end
        max_pos = MAX_POS_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: unknown codes, notes at both ends of the ROM, bad drive numbers, clears
        push_req(OP_SPARE_5, 0, 0);
        push_req(OP_SPARE_6, 5, 64);
        push_req(OP_SPARE_7, 15, 127);
        push_req(OP_NOTE_ON, 1, 71);
        push_req(OP_NOTE_ON, 9, 24);
        push_req(OP_NOTE_ON, 2, 0);
        push_req(OP_NOTE_ON, 3, 127);
        push_req(OP_NOTE_ON, 4, 23);
        push_req(OP_NOTE_ON, 5, 72);
        push_req(OP_NOTE_ON, 0, 60);
        push_req(OP_NOTE_ON, 10, 60);
        push_req(OP_NOTE_ON, 15, 60);
        push_req(OP_TICK, 0, 0);
        push_req(OP_TICK, 15, 127);
        push_req(OP_NOTE_OFF, 9, 0);
        push_req(OP_NOTE_OFF, 0, 0);
        push_req(OP_NOTE_OFF, 15, 0);
        push_req(OP_RESET, 1, 0);
        push_req(OP_RESET, 12, 0);
        push_req(OP_RESET, 0, 0);
        push_req(OP_HALT, 0, 0);
        push_req(OP_TICK, 9, 0);
        push_req(OP_NOTE_ON, 9, 71);
        push_req(OP_TICK, 1, 0);
        run_phase(200);

        wait_idle();
        set_turn_pos(8'd1);
        run_phase(220);

        wait_idle();
        set_turn_pos(8'd255);
        run_phase(180);

        // a turn position of zero: reverse steps pin the head at 0
        wait_idle();
        set_turn_pos(8'd0);
        run_phase(120);

        wait_idle();
        set_turn_pos(8'd2);
        run_phase(220);

        wait_idle();
        set_turn_pos(POS_W'($urandom_range(3, 12)));
        run_phase(200);

        // last stretch runs without idling on either side
        wait_idle();
        calm = 1'b1;
        set_turn_pos(MAX_POS_RESET);
        run_phase(200);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_rsp.size() == 0) begin
            $display("multi_drive_step_tone_generator_core test passed");
        end else begin
            $display("multi_drive_step_tone_generator_core test failed");
        end
        $finish;
    end

endmodule
